>>> hw/rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared types, constants and saturating helpers for the steering controller.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] QONE = 32'sh0001_0000;

  localparam int unsigned DEF_FILTER_TAU    = 0;
  localparam int unsigned DEF_PREDICT_TIME  = 0;
  localparam int unsigned DEF_CUBIC_GAIN    = 0;
  localparam int unsigned DEF_SLEW_STEP     = 0;
  localparam int unsigned DEF_SLOWDOWN_GAIN = 0;
  localparam int unsigned DEF_MIN_BASE      = 0;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_INTEG_BOUND   = 3'd3,
    REG_CORR_BOUND    = 3'd4,
    REG_CRUISE_SPEED  = 3'd5,
    REG_WHEEL_FLOOR   = 3'd6,
    REG_WHEEL_CEILING = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_EDT,
    ST_DIV_D,
    ST_FILT_SEL,
    ST_DIV_ALPHA,
    ST_MUL_FILT,
    ST_MUL_DTERM,
    ST_MUL_PRED,
    ST_MUL_EDGE1,
    ST_MUL_EDGE2,
    ST_MUL_EDGE3,
    ST_MUL_P,
    ST_MUL_I1,
    ST_MUL_I2,
    ST_MUL_SLOW1,
    ST_MUL_SLOW2,
    ST_FINISH,
    ST_OUT
  } seq_state_e;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? QMIN : QMAX;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? QMIN : QMAX;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [31:0] v,
                                               logic signed [31:0] lo,
                                               logic signed [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [31:0] abs_sat(logic signed [31:0] v);
    if (v == QMIN) return QMAX;
    return v[31] ? -v : v;
  endfunction

endpackage

>>> hw/rtl/lfps_serial_alu.sv
// ----------------------------------------------------------------------------
// lfps_serial_alu
// Bit-serial Q16.16 multiply (32 steps) and divide (48 steps), saturated.
// ----------------------------------------------------------------------------
module lfps_serial_alu
  import lfps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alu_ctrl_t          ctrl_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);

  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd47;

  alu_op_e     op_q, op_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] hi_q, hi_d;
  logic [31:0] lo_q, lo_d, ma_q, ma_d;
  logic [47:0] num_q, num_d;
  logic [17:0] rem_q, rem_d;
  logic [16:0] den_q, den_d;
  logic        neg_q, neg_d;

  logic [32:0] addend, sum;
  logic [17:0] rt;
  logic        ge;
  logic [31:0] ua;

  always_comb begin
    op_d   = op_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    ma_d   = ma_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    addend = {ma_q[31], ma_q};
    sum    = hi_q;
    rt     = {rem_q[16:0], num_q[47]};
    ge     = rt >= {1'b0, den_q};
    ua     = a_i[31] ? (~a_i + 32'd1) : a_i;
    if (ctrl_i.start) begin
      op_d   = ctrl_i.op;
      busy_d = 1'b1;
      cnt_d  = '0;
      if (ctrl_i.op == ALU_MUL) begin
        hi_d = '0;
        lo_d = b_i;
        ma_d = a_i;
      end else begin
        neg_d = a_i[31];
        num_d = {ua, 16'h0000};
        rem_d = '0;
        den_d = b_i[16:0];
      end
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        if (lo_q[0]) sum = (cnt_q == MUL_LAST) ? hi_q - addend : hi_q + addend;
        hi_d = {sum[32], sum[32:1]};
        lo_d = {sum[0], lo_q[31:1]};
      end else begin
        rem_d = ge ? rt - {1'b0, den_q} : rt;
        num_d = {num_q[46:0], ge};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == ((op_q == ALU_MUL) ? MUL_LAST : DIV_LAST)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    ma_q  <= ma_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // product is {hi[31:0], lo}; floor shift by 16 then saturate
  always_comb begin
    if (op_q == ALU_MUL) begin
      if ((&hi_q[31:15]) || !(|hi_q[31:15])) res_o = {hi_q[15:0], lo_q[31:16]};
      else res_o = hi_q[31] ? QMIN : QMAX;
    end else if (neg_q) begin
      if ((|num_q[47:32]) || (num_q[31] && (|num_q[30:0]))) res_o = QMIN;
      else res_o = -num_q[31:0];
    end else begin
      if (|num_q[47:31]) res_o = QMAX;
      else res_o = num_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

>>> hw/rtl/line_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering
// PID line-follow steering with anti-windup, slew limit and speed slowdown.
// ----------------------------------------------------------------------------
// channel  dir  content
// s_axis   in   tdata {step_time, line_error}, tuser line_seen
// m_axis   out  tdata {base_out, steer_out, right_speed, left_speed}, tuser tracking
// cfg      in   write enable, index, data
//
// A clear beat (line lost or zero step) skips the arithmetic and goes from accept straight to the output state.
// A control beat runs 11 or 12 multiplies and up to 2 divides on the one shared
// bit-serial unit, one after another.
// Reset clears state, output valid, integrator, filter, previous error, steer and
// base; a finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module line_follow_pid_steering
  import lfps_pkg::*;
#(
  parameter int unsigned FILTER_TAU    = DEF_FILTER_TAU,
  parameter int unsigned PREDICT_TIME  = DEF_PREDICT_TIME,
  parameter int unsigned CUBIC_GAIN    = DEF_CUBIC_GAIN,
  parameter int unsigned SLEW_STEP     = DEF_SLEW_STEP,
  parameter int unsigned SLOWDOWN_GAIN = DEF_SLOWDOWN_GAIN,
  parameter int unsigned MIN_BASE      = DEF_MIN_BASE
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // line_error[31:0], step_time[47:32]
  input  logic         s_axis_tuser,  // line_seen
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // left, right, steer_out, base_out
  output logic         m_axis_tuser,  // tracking
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam logic signed [31:0] P_TAU  = 32'(FILTER_TAU);
  localparam logic signed [31:0] P_PT   = 32'(PREDICT_TIME);
  localparam logic signed [31:0] P_EG   = 32'(CUBIC_GAIN);
  localparam logic signed [31:0] P_SLEW = 32'(SLEW_STEP);
  localparam logic signed [31:0] P_SG   = 32'(SLOWDOWN_GAIN);
  localparam logic signed [31:0] P_MINB = 32'(MIN_BASE);

  logic [30:0]        pg_q, ig_q, dg_q, ib_q, cb_q, cs_q;
  logic signed [31:0] wf_q, wc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q <= '0; ig_q <= '0; dg_q <= '0; ib_q <= '0;
      cb_q <= '0; cs_q <= '0; wf_q <= '0; wc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        REG_PROP_GAIN:     pg_q <= cfg_wdata_i[30:0];
        REG_INTEG_GAIN:    ig_q <= cfg_wdata_i[30:0];
        REG_DERIV_GAIN:    dg_q <= cfg_wdata_i[30:0];
        REG_INTEG_BOUND:   ib_q <= cfg_wdata_i[30:0];
        REG_CORR_BOUND:    cb_q <= cfg_wdata_i[30:0];
        REG_CRUISE_SPEED:  cs_q <= cfg_wdata_i[30:0];
        REG_WHEEL_FLOOR:   wf_q <= cfg_wdata_i;
        REG_WHEEL_CEILING: wc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [31:0] pg, ig, dg, ib, cb, cs;
  assign pg = {1'b0, pg_q};
  assign ig = {1'b0, ig_q};
  assign dg = {1'b0, dg_q};
  assign ib = {1'b0, ib_q};
  assign cb = {1'b0, cb_q};
  assign cs = {1'b0, cs_q};

  seq_state_e state_q, state_d;
  logic       launched_q, launched_d;
  alu_ctrl_t  alu_ctrl;
  logic signed [31:0] alu_a, alu_b, r;
  logic       alu_done;

  logic signed [31:0] e_q, e_d, cand_q, cand_d, rawd_q, rawd_d, fd_q, fd_d;
  logic signed [31:0] dterm_q, dterm_d, ce_q, ce_d, edge_term_q, edge_term_d;
  logic signed [31:0] pterm_q, pterm_d, tmp_q, tmp_d, integ_q, integ_d;
  logic signed [31:0] prev_q, prev_d, steer_q, steer_d, base_q, base_d;
  logic signed [31:0] left_q, left_d, right_q, right_d;
  logic [15:0]        dt_q, dt_d;
  logic               have_prev_q, have_prev_d, trk_q, trk_d;
  logic               ovalid_q, ovalid_d;
  logic [127:0]       odata_q, odata_d;
  logic               ouser_q, ouser_d;
  logic signed [31:0] raw, amp, des;
  logic               in_acc, in_clear, op_state;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_clear = !s_axis_tuser || (s_axis_tdata[47:32] == 16'h0000);

  lfps_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (r)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_acc) state_d = in_clear ? ST_OUT : ST_MUL_EDT;
      ST_MUL_EDT:   if (alu_done) state_d = have_prev_q ? ST_DIV_D : ST_FILT_SEL;
      ST_DIV_D:     if (alu_done) state_d = ST_FILT_SEL;
      ST_FILT_SEL:  state_d = (FILTER_TAU > 0) ? ST_DIV_ALPHA : ST_MUL_DTERM;
      ST_DIV_ALPHA: if (alu_done) state_d = ST_MUL_FILT;
      ST_MUL_FILT:  if (alu_done) state_d = ST_MUL_DTERM;
      ST_MUL_DTERM: if (alu_done) state_d = ST_MUL_PRED;
      ST_MUL_PRED:  if (alu_done) state_d = ST_MUL_EDGE1;
      ST_MUL_EDGE1: if (alu_done) state_d = ST_MUL_EDGE2;
      ST_MUL_EDGE2: if (alu_done) state_d = ST_MUL_EDGE3;
      ST_MUL_EDGE3: if (alu_done) state_d = ST_MUL_P;
      ST_MUL_P:     if (alu_done) state_d = ST_MUL_I1;
      ST_MUL_I1:    if (alu_done) state_d = ST_MUL_I2;
      ST_MUL_I2:    if (alu_done) state_d = ST_MUL_SLOW1;
      ST_MUL_SLOW1: if (alu_done) state_d = ST_MUL_SLOW2;
      ST_MUL_SLOW2: if (alu_done) state_d = ST_FINISH;
      ST_FINISH:    state_d = ST_OUT;
      ST_OUT:       if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    op_state = 1'b1;
    alu_ctrl.op = ALU_MUL;
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      ST_MUL_EDT:   begin alu_a = e_q; alu_b = {16'h0000, dt_q}; end
      ST_DIV_D:     begin
        alu_ctrl.op = ALU_DIV; alu_a = sat_sub(e_q, prev_q); alu_b = {16'h0000, dt_q};
      end
      ST_DIV_ALPHA: begin
        alu_ctrl.op = ALU_DIV; alu_a = {16'h0000, dt_q};
        alu_b = P_TAU + {16'h0000, dt_q};
      end
      ST_MUL_FILT:  begin alu_a = tmp_q; alu_b = sat_sub(rawd_q, fd_q); end
      ST_MUL_DTERM: begin alu_a = dg; alu_b = fd_q; end
      ST_MUL_PRED:  begin alu_a = P_PT; alu_b = fd_q; end
      ST_MUL_EDGE1: begin alu_a = P_EG; alu_b = ce_q; end
      ST_MUL_EDGE2: begin alu_a = tmp_q; alu_b = ce_q; end
      ST_MUL_EDGE3: begin alu_a = tmp_q; alu_b = ce_q; end
      ST_MUL_P:     begin alu_a = pg; alu_b = ce_q; end
      ST_MUL_I1:    begin alu_a = ig; alu_b = cand_q; end
      ST_MUL_I2:    begin alu_a = ig; alu_b = integ_q; end
      ST_MUL_SLOW1: begin alu_a = P_SG; alu_b = abs_sat(ce_q); end
      ST_MUL_SLOW2: begin alu_a = P_SG; alu_b = abs_sat(fd_q); end
      default:      op_state = 1'b0;
    endcase
    alu_ctrl.start = op_state && !launched_q;
    launched_d = op_state && !alu_done;
  end

  // datapath
  always_comb begin
    e_d = e_q; dt_d = dt_q; cand_d = cand_q; rawd_d = rawd_q; fd_d = fd_q;
    dterm_d = dterm_q; ce_d = ce_q; edge_term_d = edge_term_q; pterm_d = pterm_q;
    tmp_d = tmp_q; integ_d = integ_q; prev_d = prev_q; have_prev_d = have_prev_q;
    steer_d = steer_q; base_d = base_q; left_d = left_q; right_d = right_q;
    trk_d = trk_q; ovalid_d = ovalid_q; odata_d = odata_q; ouser_d = ouser_q;
    raw = sat_add(sat_add(sat_add(pterm_q, r), dterm_q), edge_term_q);
    amp = clamp(raw, -cb, cb);
    des = sat_sub(tmp_q, r);
    if (m_axis_tready) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_acc) begin
        e_d  = s_axis_tdata[31:0];
        dt_d = s_axis_tdata[47:32];
        if (in_clear) begin
          integ_d = '0; fd_d = '0; prev_d = '0; have_prev_d = 1'b0;
          steer_d = '0; base_d = '0; left_d = '0; right_d = '0; trk_d = 1'b0;
        end
      end
      ST_MUL_EDT: if (alu_done) begin
        cand_d = clamp(sat_add(integ_q, r), -ib, ib);
        rawd_d = '0;
      end
      ST_DIV_D:     if (alu_done) rawd_d = r;
      ST_FILT_SEL:  if (FILTER_TAU == 0) fd_d = rawd_q;
      ST_DIV_ALPHA: if (alu_done) tmp_d = r;
      ST_MUL_FILT:  if (alu_done) fd_d = sat_add(fd_q, r);
      ST_MUL_DTERM: if (alu_done) dterm_d = r;
      ST_MUL_PRED:  if (alu_done) ce_d = clamp(sat_add(e_q, r), -QONE, QONE);
      ST_MUL_EDGE1: if (alu_done) tmp_d = r;
      ST_MUL_EDGE2: if (alu_done) tmp_d = r;
      ST_MUL_EDGE3: if (alu_done) edge_term_d = r;
      ST_MUL_P:     if (alu_done) pterm_d = r;
      ST_MUL_I1: if (alu_done) begin
        if ((raw < cb || e_q[31]) && (raw > -cb || (!e_q[31] && e_q != 0)))
          integ_d = cand_q;
      end
      ST_MUL_I2: if (alu_done) begin
        if (SLEW_STEP > 0)
          steer_d = clamp(amp, sat_sub(steer_q, P_SLEW), sat_add(steer_q, P_SLEW));
        else
          steer_d = amp;
      end
      ST_MUL_SLOW1: if (alu_done) tmp_d = sat_sub(cs, r);
      ST_MUL_SLOW2: if (alu_done) begin
        if (SLEW_STEP > 0 && have_prev_q)
          base_d = clamp(clamp(des, P_MINB, cs), sat_sub(base_q, P_SLEW),
                         sat_add(base_q, P_SLEW));
        else
          base_d = clamp(des, P_MINB, cs);
      end
      ST_FINISH: begin
        left_d  = clamp(sat_add(base_q, steer_q), wf_q, wc_q);
        right_d = clamp(sat_sub(base_q, steer_q), wf_q, wc_q);
        prev_d = e_q; have_prev_d = 1'b1; trk_d = 1'b1;
      end
      ST_OUT: if (!ovalid_q || m_axis_tready) begin
        ovalid_d = 1'b1;
        odata_d  = {base_q, steer_q, right_q, left_q};
        ouser_d  = trk_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; launched_q <= 1'b0; ovalid_q <= 1'b0;
      integ_q <= '0; fd_q <= '0; prev_q <= '0; have_prev_q <= 1'b0;
      steer_q <= '0; base_q <= '0;
    end else begin
      state_q <= state_d; launched_q <= launched_d; ovalid_q <= ovalid_d;
      integ_q <= integ_d; fd_q <= fd_d; prev_q <= prev_d; have_prev_q <= have_prev_d;
      steer_q <= steer_d; base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; dt_q <= dt_d; cand_q <= cand_d; rawd_q <= rawd_d;
    dterm_q <= dterm_d; ce_q <= ce_d; edge_term_q <= edge_term_d; pterm_q <= pterm_d;
    tmp_q <= tmp_d; left_q <= left_d; right_q <= right_d; trk_q <= trk_d;
    odata_q <= odata_d; ouser_q <= ouser_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

`ifndef SYNTHESIS
  a_clear_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_clear |=> !have_prev_q && integ_q == 0 && steer_q == 0)
    else $error("state not cleared");
  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("cleared beat with nonzero speeds");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> state_q != ST_IDLE && state_q != ST_OUT && launched_q)
    else $error("unit done without a launched op");
`endif

endmodule
